>>> design/nps_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the nonpreemptive priority scheduler
// no dependencies; used by nps_ctrl, nps_datapath and the top level

package nps_pkg;

    localparam int DEF_MAX_PROCS = 16;

    localparam int ARR_W     = 16;
    localparam int BURST_W   = 16;
    localparam int PRI_W     = 8;
    localparam int TICK_W    = 21;
    localparam int SUM_W     = 25;
    localparam int JOB_IDX_W = 4;

    typedef logic [ARR_W-1:0]     arr_t;
    typedef logic [BURST_W-1:0]   burst_t;
    typedef logic [PRI_W-1:0]     pri_t;
    typedef logic [TICK_W-1:0]    tick_t;
    typedef logic [SUM_W-1:0]     sum_t;
    typedef logic [JOB_IDX_W-1:0] job_idx_t;

    localparam tick_t TICK_MAX = '1;
    localparam sum_t  SUM_MAX  = '1;
    localparam arr_t  ARR_MAX  = '1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;      // input transfer: store the job
        logic scan_init; // first read of a selection scan: clear best candidate
        logic scan_rd;   // scan read issued this cycle
        logic jump;      // nothing ready: move the clock to the earliest arrival
        logic exec;      // run the picked job: advance the clock
        logic sum1;      // record completion, accumulate waiting
        logic sum2;      // accumulate turnaround
        logic out_calc;  // report: turnaround from read data
        logic out_load;  // report: fill the output registers
        logic out_last;  // report of the highest index
        logic clear;     // batch done: clear counters, clock, sums, flags
    } nps_cmd_t;

endpackage

>>> design/nps_ctrl.sv
`timescale 1ns / 1ps
// controller of the scheduler: state machine, scan/report index and done counter
// depends on nps_pkg for the command struct

module nps_ctrl #(
    parameter int MAX_PROCS = nps_pkg::DEF_MAX_PROCS,
    localparam int CW = $clog2(MAX_PROCS + 1),
    localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             last_job,
    input  logic             out_stall,
    input  logic [CW-1:0]    job_count,
    input  logic             found,
    output logic             in_stall,
    output logic             out_valid,
    output logic [IW-1:0]    rd_addr,
    output nps_pkg::nps_cmd_t cmd
);

    typedef enum logic [10:0] {
        ST_IDLE     = 11'b000_0000_0001,
        ST_SCAN     = 11'b000_0000_0010,
        ST_DRAIN    = 11'b000_0000_0100,
        ST_DECIDE   = 11'b000_0000_1000,
        ST_EXEC     = 11'b000_0001_0000,
        ST_SUM1     = 11'b000_0010_0000,
        ST_SUM2     = 11'b000_0100_0000,
        ST_OUT_RD   = 11'b000_1000_0000,
        ST_OUT_CALC = 11'b001_0000_0000,
        ST_OUT_LOAD = 11'b010_0000_0000,
        ST_OUT_SEND = 11'b100_0000_0000
    } state_t;

    state_t         state_reg, state_next;
    logic [IW-1:0]  idx_reg, idx_next;
    logic [CW-1:0]  done_reg, done_next;
    logic           idx_last;
    logic           in_xfer;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_OUT_SEND);
    assign in_xfer   = in_valid && !in_stall;
    assign rd_addr   = idx_reg;
    assign idx_last  = ((CW'(idx_reg) + CW'(1)) == job_count);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        done_next  = done_reg;
        cmd        = '0;
        cmd.load     = in_xfer;
        cmd.out_last = idx_last;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && last_job)
                begin
                    state_next = ST_SCAN;
                    idx_next   = '0;
                    done_next  = '0;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_rd   = 1'b1;
                cmd.scan_init = (idx_reg == '0);
                if (idx_last)
                    state_next = ST_DRAIN;
                else
                    idx_next = idx_reg + IW'(1);
            end
            ST_DRAIN:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                idx_next = '0;
                if (found)
                    state_next = ST_EXEC;
                else
                begin
                    cmd.jump   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_SUM1;
            end
            ST_SUM1:
            begin
                cmd.sum1   = 1'b1;
                done_next  = done_reg + CW'(1);
                state_next = ST_SUM2;
            end
            ST_SUM2:
            begin
                cmd.sum2 = 1'b1;
                idx_next = '0;
                if (done_reg == job_count)
                    state_next = ST_OUT_RD;
                else
                    state_next = ST_SCAN;
            end
            ST_OUT_RD:
            begin
                state_next = ST_OUT_CALC;
            end
            ST_OUT_CALC:
            begin
                cmd.out_calc = 1'b1;
                state_next   = ST_OUT_LOAD;
            end
            ST_OUT_LOAD:
            begin
                cmd.out_load = 1'b1;
                state_next   = ST_OUT_SEND;
            end
            ST_OUT_SEND:
            begin
                if (!out_stall)
                begin
                    if (idx_last)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IW'(1);
                        state_next = ST_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            done_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            done_reg  <= done_next;
        end
    end

endmodule

>>> design/nps_datapath.sv
`timescale 1ns / 1ps
// datapath of the scheduler: job memories, selection compare, clock, sums, report registers
// depends on nps_pkg for field types, limits and the command struct

module nps_datapath #(
    parameter int MAX_PROCS = nps_pkg::DEF_MAX_PROCS,
    localparam int CW = $clog2(MAX_PROCS + 1),
    localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  nps_pkg::nps_cmd_t    cmd,
    input  logic [IW-1:0]        rd_addr,
    input  nps_pkg::arr_t        arrival_time,
    input  nps_pkg::burst_t      burst_length,
    input  nps_pkg::pri_t        job_priority,
    output logic [CW-1:0]        job_count,
    output logic                 found,
    output nps_pkg::job_idx_t    job_index,
    output nps_pkg::tick_t       completion_time,
    output nps_pkg::tick_t       waiting_time,
    output nps_pkg::tick_t       turnaround_time,
    output nps_pkg::sum_t        total_waiting,
    output nps_pkg::sum_t        total_turnaround,
    output logic                 last_result
);

    // job memories
    nps_pkg::arr_t   arr_mem  [MAX_PROCS];
    nps_pkg::burst_t bur_mem  [MAX_PROCS];
    nps_pkg::pri_t   pri_mem  [MAX_PROCS];
    nps_pkg::tick_t  comp_mem [MAX_PROCS];

    nps_pkg::arr_t   rd_arr_reg;
    nps_pkg::burst_t rd_bur_reg;
    nps_pkg::pri_t   rd_pri_reg;
    nps_pkg::tick_t  rd_comp_reg;

    logic [CW-1:0]        job_count_reg;
    logic [MAX_PROCS-1:0] fin_reg;
    nps_pkg::tick_t       tick_reg;
    nps_pkg::sum_t        wait_sum_reg;
    nps_pkg::sum_t        tat_sum_reg;
    logic                 cmp_en_reg;
    logic                 found_reg;

    logic [IW-1:0]   idx_d_reg;
    logic [IW-1:0]   best_idx_reg;
    nps_pkg::pri_t   best_pri_reg;
    nps_pkg::arr_t   best_arr_reg;
    nps_pkg::burst_t best_bur_reg;
    nps_pkg::arr_t   min_arr_reg;
    nps_pkg::tick_t  wait_val_reg;
    nps_pkg::tick_t  tat_val_reg;
    nps_pkg::tick_t  calc_tat_reg;

    nps_pkg::job_idx_t out_idx_reg;
    nps_pkg::tick_t    out_comp_reg;
    nps_pkg::tick_t    out_wait_reg;
    nps_pkg::tick_t    out_tat_reg;
    nps_pkg::sum_t     out_twait_reg;
    nps_pkg::sum_t     out_ttat_reg;
    logic              out_last_reg;

    logic                          room;
    logic                          eligible;
    logic                          better;
    logic                          take;
    logic [nps_pkg::TICK_W:0]      tick_sum;
    nps_pkg::tick_t                tick_sat;
    logic [nps_pkg::SUM_W:0]       wsum;
    logic [nps_pkg::SUM_W:0]       tsum;
    nps_pkg::tick_t                bur_ext;

    assign job_count = job_count_reg;
    assign found     = found_reg;
    assign room      = (job_count_reg < CW'(MAX_PROCS));

    // candidate test on the entry read last cycle
    assign eligible = !fin_reg[idx_d_reg] && (nps_pkg::tick_t'(rd_arr_reg) <= tick_reg);
    assign better   = !found_reg || (rd_pri_reg < best_pri_reg)
                      || ((rd_pri_reg == best_pri_reg) && (rd_arr_reg < best_arr_reg));
    assign take     = cmp_en_reg && eligible && better;

    // saturating clock advance and sums
    assign tick_sum = {1'b0, tick_reg} + (nps_pkg::TICK_W+1)'(best_bur_reg);
    assign tick_sat = tick_sum[nps_pkg::TICK_W] ? nps_pkg::TICK_MAX
                                                : tick_sum[nps_pkg::TICK_W-1:0];
    assign wsum     = {1'b0, wait_sum_reg} + (nps_pkg::SUM_W+1)'(wait_val_reg);
    assign tsum     = {1'b0, tat_sum_reg} + (nps_pkg::SUM_W+1)'(tat_val_reg);
    assign bur_ext  = nps_pkg::tick_t'(rd_bur_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load && room)
        begin
            arr_mem[job_count_reg[IW-1:0]] <= arrival_time;
            bur_mem[job_count_reg[IW-1:0]] <= burst_length;
            pri_mem[job_count_reg[IW-1:0]] <= job_priority;
        end
        if (cmd.sum1)
            comp_mem[best_idx_reg] <= tick_reg;
    end

    always_ff @(posedge clk)
    begin
        rd_arr_reg  <= arr_mem[rd_addr];
        rd_bur_reg  <= bur_mem[rd_addr];
        rd_pri_reg  <= pri_mem[rd_addr];
        rd_comp_reg <= comp_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_count_reg <= '0;
            fin_reg       <= '0;
            tick_reg      <= '0;
            wait_sum_reg  <= '0;
            tat_sum_reg   <= '0;
            cmp_en_reg    <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            cmp_en_reg <= cmd.scan_rd;
            if (cmd.scan_init)
                found_reg <= 1'b0;
            else if (take)
                found_reg <= 1'b1;
            if (cmd.clear)
            begin
                job_count_reg <= '0;
                fin_reg       <= '0;
                tick_reg      <= '0;
                wait_sum_reg  <= '0;
                tat_sum_reg   <= '0;
            end
            else
            begin
                if (cmd.load && room)
                begin
                    job_count_reg <= job_count_reg + CW'(1);
                    fin_reg[job_count_reg[IW-1:0]] <= 1'b0;
                end
                if (cmd.jump)
                    tick_reg <= nps_pkg::tick_t'(min_arr_reg);
                if (cmd.exec)
                    tick_reg <= tick_sat;
                if (cmd.sum1)
                begin
                    fin_reg[best_idx_reg] <= 1'b1;
                    wait_sum_reg <= wsum[nps_pkg::SUM_W] ? nps_pkg::SUM_MAX
                                                         : wsum[nps_pkg::SUM_W-1:0];
                end
                if (cmd.sum2)
                    tat_sum_reg <= tsum[nps_pkg::SUM_W] ? nps_pkg::SUM_MAX
                                                        : tsum[nps_pkg::SUM_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_d_reg <= rd_addr;
        if (cmd.scan_init)
            min_arr_reg <= nps_pkg::ARR_MAX;
        else if (cmp_en_reg && !fin_reg[idx_d_reg] && (rd_arr_reg < min_arr_reg))
            min_arr_reg <= rd_arr_reg;
        if (take)
        begin
            best_idx_reg <= idx_d_reg;
            best_pri_reg <= rd_pri_reg;
            best_arr_reg <= rd_arr_reg;
            best_bur_reg <= rd_bur_reg;
        end
        if (cmd.exec)
            wait_val_reg <= tick_reg - nps_pkg::tick_t'(best_arr_reg);
        if (cmd.sum1)
            tat_val_reg <= tick_reg - nps_pkg::tick_t'(best_arr_reg);
        if (cmd.out_calc)
            calc_tat_reg <= rd_comp_reg - nps_pkg::tick_t'(rd_arr_reg);
        if (cmd.out_load)
        begin
            out_idx_reg   <= nps_pkg::job_idx_t'(rd_addr);
            out_comp_reg  <= rd_comp_reg;
            out_tat_reg   <= calc_tat_reg;
            // saturated clock can leave less than the burst
            out_wait_reg  <= (bur_ext > calc_tat_reg) ? '0 : calc_tat_reg - bur_ext;
            out_twait_reg <= cmd.out_last ? wait_sum_reg : '0;
            out_ttat_reg  <= cmd.out_last ? tat_sum_reg : '0;
            out_last_reg  <= cmd.out_last;
        end
    end

    assign job_index        = out_idx_reg;
    assign completion_time  = out_comp_reg;
    assign waiting_time     = out_wait_reg;
    assign turnaround_time  = out_tat_reg;
    assign total_waiting    = out_twait_reg;
    assign total_turnaround = out_ttat_reg;
    assign last_result      = out_last_reg;

endmodule

>>> design/nonpreemptive_priority_scheduler.sv
`timescale 1ns / 1ps
// Non-preemptive priority scheduler over a batch of up to MAX_PROCS jobs.
// Input channel (in_valid / in_stall): one job per transfer, one per cycle while
//   idle. Jobs beyond MAX_PROCS are dropped. A job with last_job set closes the
//   batch; in_stall then stays high until the last report has been taken.
// Scheduling: each decision is a scan over the n held jobs through the job
//   memory read port, then a drain and a decide state, followed by the exec,
//   sum1 and sum2 states to run the picked job. A decision that finds nothing
//   ready moves the clock to the earliest pending arrival and scans again.
// Output channel (out_valid / out_stall): one report per job in load order,
//   each read, calculated and loaded before it is shown. A stalled report
//   holds its payload. last_result marks the final report, which alone carries
//   the totals; its transfer clears the batch and the block is idle next cycle.
// Reset: asynchronous, active low; the block comes up idle with an empty batch.
//   Job memories are not cleared; only entries loaded in the current batch are read.
// Depends on nps_pkg, nps_ctrl and nps_datapath.

module nonpreemptive_priority_scheduler #(
    parameter int MAX_PROCS = nps_pkg::DEF_MAX_PROCS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  nps_pkg::arr_t        arrival_time,
    input  nps_pkg::burst_t      burst_length,
    input  nps_pkg::pri_t        job_priority,
    input  logic                 last_job,
    output logic                 out_valid,
    input  logic                 out_stall,
    output nps_pkg::job_idx_t    job_index,
    output nps_pkg::tick_t       completion_time,
    output nps_pkg::tick_t       waiting_time,
    output nps_pkg::tick_t       turnaround_time,
    output nps_pkg::sum_t        total_waiting,
    output nps_pkg::sum_t        total_turnaround,
    output logic                 last_result
);

    localparam int CW = $clog2(MAX_PROCS + 1);
    localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;

    nps_pkg::nps_cmd_t cmd;
    logic [IW-1:0]     rd_addr;
    logic [CW-1:0]     job_count;
    logic              found;

    nps_ctrl #(
        .MAX_PROCS (MAX_PROCS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .last_job  (last_job),
        .out_stall (out_stall),
        .job_count (job_count),
        .found     (found),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .rd_addr   (rd_addr),
        .cmd       (cmd)
    );

    nps_datapath #(
        .MAX_PROCS (MAX_PROCS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .rd_addr          (rd_addr),
        .arrival_time     (arrival_time),
        .burst_length     (burst_length),
        .job_priority     (job_priority),
        .job_count        (job_count),
        .found            (found),
        .job_index        (job_index),
        .completion_time  (completion_time),
        .waiting_time     (waiting_time),
        .turnaround_time  (turnaround_time),
        .total_waiting    (total_waiting),
        .total_turnaround (total_turnaround),
        .last_result      (last_result)
    );

    // no new job is taken while a report is shown
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> in_stall)
        else $error("input taken while a report is pending");

    // job count never passes the store depth
    assert property (@(posedge clk) disable iff (!rst_n) job_count <= CW'(MAX_PROCS))
        else $error("job count beyond store depth");

    // a job is only run after the scan found a candidate
    assert property (@(posedge clk) disable iff (!rst_n) cmd.exec |-> found)
        else $error("job run without a candidate");

    // transfer of the final report returns the block to idle with an empty batch
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && last_result) |=> (!in_stall && job_count == '0))
        else $error("batch not cleared after final report");

endmodule

>>> sim/tb_nonpreemptive_priority_scheduler.sv
`timescale 1ns / 1ps
// self-checking testbench for nonpreemptive_priority_scheduler: job batches in,
// per-job reports out, compared against a schedule computed here
// depends on nps_pkg and the design top level

module tb_nonpreemptive_priority_scheduler;

    localparam int MAX_JOBS    = nps_pkg::DEF_MAX_PROCS;
    localparam int QUIET_LIMIT = 5000;

    typedef struct {
        nps_pkg::job_idx_t idx;
        nps_pkg::tick_t    done_at;
        nps_pkg::tick_t    waited;
        nps_pkg::tick_t    turnaround;
        nps_pkg::sum_t     wait_total;
        nps_pkg::sum_t     turn_total;
        logic              last;
    } job_report_t;

    class schedule_board;
        nps_pkg::arr_t   arr_mem[MAX_JOBS];
        nps_pkg::burst_t burst_mem[MAX_JOBS];
        nps_pkg::pri_t   pri_mem[MAX_JOBS];
        bit              finished[MAX_JOBS];
        nps_pkg::tick_t  done_mem[MAX_JOBS];
        int unsigned     held;
        nps_pkg::tick_t  now;
        nps_pkg::sum_t   wait_acc;
        nps_pkg::sum_t   turn_acc;
        job_report_t     job_reports[$];
        int              errors;
        int              checked;
        int              dropped;
        int              batches;

        function new();
            held = 0;
            now = '0;
            wait_acc = '0;
            turn_acc = '0;
            errors = 0;
            checked = 0;
            dropped = 0;
            batches = 0;
            foreach (finished[i]) finished[i] = 1'b0;
        endfunction

        function longint unsigned clamp(longint unsigned v, longint unsigned lim);
            return (v > lim) ? lim : v;
        endfunction

        // one accepted input transfer
        function void load_job(nps_pkg::arr_t a, nps_pkg::burst_t b, nps_pkg::pri_t p,
                               logic last);
            if (held < MAX_JOBS)
            begin
                arr_mem[held] = a;
                burst_mem[held] = b;
                pri_mem[held] = p;
                finished[held] = 1'b0;
                held++;
            end
            else
            begin
                dropped++;
            end
            if (last)
                run_schedule();
        endfunction

        function void run_schedule();
            int unsigned       count_done;
            int unsigned       pick;
            bit                found;
            longint unsigned   w;
            longint unsigned   tat;
            longint unsigned   wt;
            nps_pkg::tick_t    next_arr;
            job_report_t       r;
            count_done = 0;
            while (count_done < held)
            begin
                found = 1'b0;
                pick = 0;
                for (int i = 0; i < held; i++)
                begin
                    if (!finished[i] && arr_mem[i] <= now)
                    begin
                        if (!found || pri_mem[i] < pri_mem[pick] ||
                            (pri_mem[i] == pri_mem[pick] && arr_mem[i] < arr_mem[pick]))
                        begin
                            found = 1'b1;
                            pick = i;
                        end
                    end
                end
                if (found)
                begin
                    w = now - arr_mem[pick];
                    now = nps_pkg::tick_t'(clamp(longint'(now) + burst_mem[pick],
                                                 nps_pkg::TICK_MAX));
                    done_mem[pick] = now;
                    finished[pick] = 1'b1;
                    wait_acc = nps_pkg::sum_t'(clamp(longint'(wait_acc) + w,
                                                     nps_pkg::SUM_MAX));
                    turn_acc = nps_pkg::sum_t'(clamp(longint'(turn_acc)
                                                     + (now - arr_mem[pick]),
                                                     nps_pkg::SUM_MAX));
                    count_done++;
                end
                else
                begin
                    // nothing ready: jump to the earliest pending arrival
                    next_arr = nps_pkg::TICK_MAX;
                    for (int i = 0; i < held; i++)
                        if (!finished[i] && arr_mem[i] < next_arr)
                            next_arr = arr_mem[i];
                    now = next_arr;
                end
            end
            for (int k = 0; k < held; k++)
            begin
                tat = done_mem[k] - arr_mem[k];
                wt = (burst_mem[k] > tat) ? 0 : tat - burst_mem[k];
                r.idx = nps_pkg::job_idx_t'(k);
                r.done_at = done_mem[k];
                r.waited = nps_pkg::tick_t'(wt);
                r.turnaround = nps_pkg::tick_t'(tat);
                r.last = (k == held - 1);
                r.wait_total = r.last ? wait_acc : '0;
                r.turn_total = r.last ? turn_acc : '0;
                job_reports.push_back(r);
            end
            batches++;
            held = 0;
            now = '0;
            wait_acc = '0;
            turn_acc = '0;
            foreach (finished[i]) finished[i] = 1'b0;
        endfunction

        function void note_error(string msg);
            errors++;
            if (errors <= 10)
                $display("%s", msg);
        endfunction

        // one accepted output transfer
        function void check_report(nps_pkg::job_idx_t idx, nps_pkg::tick_t ct,
                                   nps_pkg::tick_t wt, nps_pkg::tick_t tat,
                                   nps_pkg::sum_t tw, nps_pkg::sum_t tt, logic last);
            job_report_t e;
            if (job_reports.size() == 0)
            begin
                note_error($sformatf("unexpected report: job %0d ct %0d", idx, ct));
                return;
            end
            e = job_reports.pop_front();
            checked++;
            if (e.idx !== idx || e.done_at !== ct || e.waited !== wt ||
                e.turnaround !== tat || e.wait_total !== tw || e.turn_total !== tt ||
                e.last !== last)
                note_error($sformatf({"report error: exp job %0d ct %0d wt %0d tat %0d ",
                    "tw %0d tt %0d last %0d / got job %0d ct %0d wt %0d tat %0d ",
                    "tw %0d tt %0d last %0d"},
                    e.idx, e.done_at, e.waited, e.turnaround, e.wait_total, e.turn_total,
                    e.last, idx, ct, wt, tat, tw, tt, last));
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    nps_pkg::arr_t     arrival_time = '0;
    nps_pkg::burst_t   burst_length = '0;
    nps_pkg::pri_t     job_priority = '0;
    logic              last_job = 1'b0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    nps_pkg::job_idx_t job_index;
    nps_pkg::tick_t    completion_time;
    nps_pkg::tick_t    waiting_time;
    nps_pkg::tick_t    turnaround_time;
    nps_pkg::sum_t     total_waiting;
    nps_pkg::sum_t     total_turnaround;
    logic              last_result;

    int send_idle = 14;
    int recv_idle = 65;
    int jobs_sent = 0;
    int quiet_cycles = 0;

    schedule_board board = new();

    nonpreemptive_priority_scheduler uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .arrival_time     (arrival_time),
        .burst_length     (burst_length),
        .job_priority     (job_priority),
        .last_job         (last_job),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .job_index        (job_index),
        .completion_time  (completion_time),
        .waiting_time     (waiting_time),
        .turnaround_time  (turnaround_time),
        .total_waiting    (total_waiting),
        .total_turnaround (total_turnaround),
        .last_result      (last_result)
    );

    always #5 clk = ~clk;

    // receiver: random stall, check every report transfer
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_report(job_index, completion_time, waiting_time, turnaround_time,
                               total_waiting, total_turnaround, last_result);
        out_stall <= ($urandom_range(99) < recv_idle);
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("nonpreemptive_priority_scheduler: mismatch");
            $finish;
        end
    end

    task automatic send_job(nps_pkg::arr_t a, nps_pkg::burst_t b, nps_pkg::pri_t p,
                            logic last);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        arrival_time <= a;
        burst_length <= b;
        job_priority <= p;
        last_job <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.load_job(a, b, p, last);
        jobs_sent++;
    endtask

    task automatic random_batch(int size);
        int              mode_a;
        int              mode_p;
        int              step;
        nps_pkg::arr_t   a;
        nps_pkg::burst_t b;
        nps_pkg::pri_t   p;
        mode_a = $urandom_range(3);
        mode_p = $urandom_range(2);
        step = $urandom_range(50);
        for (int j = 0; j < size; j++)
        begin
            case (mode_a)
                0: a = nps_pkg::arr_t'($urandom_range(30));
                1: a = nps_pkg::arr_t'($urandom);
                2: a = nps_pkg::ARR_MAX - nps_pkg::arr_t'($urandom_range(200));
                default: a = nps_pkg::arr_t'(j * step);
            endcase
            if ($urandom_range(3) == 0)
                b = nps_pkg::burst_t'($urandom);
            else
                b = nps_pkg::burst_t'($urandom_range(12));
            case (mode_p)
                0: p = nps_pkg::pri_t'($urandom_range(2));
                1: p = nps_pkg::pri_t'($urandom);
                default: p = 8'hFF - nps_pkg::pri_t'($urandom_range(2));
            endcase
            send_job(a, b, p, j == size - 1);
        end
    endtask

    task automatic random_phase(int items);
        int start;
        int r;
        int size;
        start = jobs_sent;
        while (jobs_sent - start < items)
        begin
            r = $urandom_range(99);
            if (r < 10)
                size = $urandom_range(MAX_JOBS + 4, MAX_JOBS + 1);
            else if (r < 20)
                size = MAX_JOBS;
            else if (r < 55)
                size = $urandom_range(4, 1);
            else
                size = $urandom_range(MAX_JOBS - 1, 5);
            random_batch(size);
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single jobs at both extremes of every field
        send_job('0, '0, '0, 1'b1);
        send_job(nps_pkg::ARR_MAX, 16'hFFFF, 8'hFF, 1'b1);
        // equal priority: earlier arrival first, then lower index
        send_job(16'd5, 16'd3, 8'd7, 1'b0);
        send_job(16'd5, 16'd2, 8'd7, 1'b0);
        send_job(16'd2, 16'd4, 8'd7, 1'b0);
        send_job(16'd9, 16'd0, 8'd0, 1'b1);
        // idle clock has to jump forward, zero burst
        send_job(16'd100, 16'd10, 8'd1, 1'b0);
        send_job(16'd0, 16'd5, 8'd9, 1'b0);
        send_job(16'd500, 16'd0, 8'd3, 1'b1);
        // full store, closing job is dropped but the batch still runs
        for (int i = 0; i <= MAX_JOBS; i++)
            send_job(nps_pkg::arr_t'(i * 3), nps_pkg::burst_t'(MAX_JOBS + 1 - i),
                     nps_pkg::pri_t'(i % 4), i == MAX_JOBS);

        random_phase(130);
        send_idle = 65;
        recv_idle = 14;
        random_phase(130);
        send_idle = 0;
        recv_idle = 0;
        random_phase(130);

        in_valid <= 1'b0;
        while (board.job_reports.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("covered %0d jobs in %0d batches, %0d past the store limit",
                 jobs_sent, board.batches, board.dropped);
        $display("%0d job reports checked, %0d errors", board.checked, board.errors);
        if (board.errors == 0 && board.job_reports.size() == 0)
            $display("nonpreemptive_priority_scheduler: match");
        else
            $display("nonpreemptive_priority_scheduler: mismatch");
        $finish;
    end

endmodule
